/* rtl/sdsp_pkg.sv */
// Shared types and constants for the serial decimal stepper positioner.
// Holds the item structs, the command class and the coil phase table.
// Has no dependencies; every rtl file takes names from here by scope.
package sdsp_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 3;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_NINE   = 8'h39;
  localparam logic [9:0]  POS_MAX     = 10'd999;
  localparam logic [15:0] PHASE_RESET = 16'd12000;
  localparam logic [3:0]  COIL_PHASE0 = 4'h5;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_TICK,
    CLS_CR,
    CLS_DIGIT
  } cls_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_done;
    logic [3:0] coil_drive;
    logic [9:0] position;
    logic       moving;
  } out_item_t;

  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  function automatic logic [3:0] coil_of(input logic [1:0] phase);
    logic [3:0] c;
    case (phase)
      2'd0:    c = 4'h5;
      2'd1:    c = 4'h6;
      2'd2:    c = 4'hA;
      2'd3:    c = 4'h9;
      default: c = 4'h5;
    endcase
    return c;
  endfunction

endpackage

/* rtl/sdsp_front.sv */
// Front end: classifies an incoming item into a command for the queue.
// Uses sdsp_pkg for the item and command types.
module sdsp_front (
  input  sdsp_pkg::in_item_t item_i,
  output sdsp_pkg::cmd_t     cmd_o
);

  always_comb begin
    cmd_o.ch = item_i.rx_byte;
    if (item_i.op) begin
      cmd_o.cls = sdsp_pkg::CLS_TICK;
    end else if (item_i.rx_byte == sdsp_pkg::CHAR_CR) begin
      cmd_o.cls = sdsp_pkg::CLS_CR;
    end else if (item_i.rx_byte inside {[sdsp_pkg::CHAR_ZERO:sdsp_pkg::CHAR_NINE]}) begin
      cmd_o.cls = sdsp_pkg::CLS_DIGIT;
    end else begin
      cmd_o.cls = sdsp_pkg::CLS_NONE;
    end
  end

endmodule

/* rtl/sdsp_queue.sv */
// Short command queue between the front end and the execution unit.
// Uses sdsp_pkg for the command and status types.
module sdsp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sdsp_pkg::cmd_t    push_cmd_i,
  input  logic              pop_i,
  output sdsp_pkg::cmd_t    head_o,
  output sdsp_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(sdsp_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(sdsp_pkg::QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(sdsp_pkg::QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(sdsp_pkg::QUEUE_DEPTH - 1);

  sdsp_pkg::cmd_t  mem_q [sdsp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  assign head_o           = mem_q[rd_q];
  assign stat_o.full      = (cnt_q == Depth);
  assign stat_o.not_empty = (cnt_q != '0);

endmodule

/* rtl/sdsp_back.sv */
// Execution unit: one command per cycle unless a held result stalls;
// updates digit, target, motion state; registers results. Uses sdsp_pkg.
module sdsp_back #(
  parameter int unsigned MaxDigits = sdsp_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                cmd_valid_i,
  input  sdsp_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdsp_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(MaxDigits + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxDigits);

  logic [15:0]     phase_ticks_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [9:0]      acc_q, acc_d;
  logic [9:0]      tgt_q, tgt_d;
  logic [9:0]      cur_q, cur_d;
  logic [1:0]      phase_q, phase_d;
  logic [15:0]     hold_q, hold_d;
  logic            out_valid_q;
  sdsp_pkg::out_item_t out_q, out_d;

  logic [13:0] acc_next;
  logic [15:0] hold_inc;
  logic [11:0] here, goal, here_step;
  logic        moving_now;

  assign pop_o      = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign acc_next   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {10'd0, cmd_i.ch[3:0]};
  assign hold_inc   = hold_q + 16'd1;
  assign here       = {cur_q, phase_q};
  assign goal       = {tgt_q, 2'b00};
  assign moving_now = (cur_q != tgt_q) || (phase_q != 2'd0);

  always_comb begin
    if (here < goal) begin
      here_step = here + 12'd1;
    end else if (here > goal) begin
      here_step = here - 12'd1;
    end else begin
      here_step = here;
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    tgt_d   = tgt_q;
    cur_d   = cur_q;
    phase_d = phase_q;
    hold_d  = hold_q;
    out_d.echo_valid = 1'b0;
    out_d.echo_byte  = 8'd0;
    out_d.line_done  = 1'b0;
    case (cmd_i.cls)
      sdsp_pkg::CLS_TICK: begin
        if (!moving_now) begin
          hold_d = '0;
        end else if (hold_inc >= phase_ticks_q) begin
          hold_d  = '0;
          cur_d   = here_step[11:2];
          phase_d = here_step[1:0];
        end else begin
          hold_d = hold_inc;
        end
      end
      sdsp_pkg::CLS_CR: begin
        out_d.line_done = 1'b1;
        if (cnt_q != '0) begin
          tgt_d = acc_q;
          cnt_d = '0;
          acc_d = '0;
        end
      end
      sdsp_pkg::CLS_DIGIT: begin
        if (cnt_q < MaxCnt) begin
          cnt_d = cnt_q + 1'b1;
          acc_d = (acc_next > {4'd0, sdsp_pkg::POS_MAX}) ? sdsp_pkg::POS_MAX : acc_next[9:0];
          out_d.echo_valid = 1'b1;
          out_d.echo_byte  = cmd_i.ch;
        end
      end
      default: begin
      end
    endcase
    out_d.coil_drive = sdsp_pkg::coil_of(phase_d);
    out_d.position   = cur_d;
    out_d.moving     = (cur_d != tgt_d) || (phase_d != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= sdsp_pkg::PHASE_RESET;
      cnt_q         <= '0;
      acc_q         <= '0;
      tgt_q         <= '0;
      cur_q         <= '0;
      phase_q       <= '0;
      hold_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        cnt_q   <= cnt_d;
        acc_q   <= acc_d;
        tgt_q   <= tgt_d;
        cur_q   <= cur_d;
        phase_q <= phase_d;
        hold_q  <= hold_d;
      end
      out_valid_q <= pop_o || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/serial_decimal_stepper_positioner_unit.sv */
// Top level of the serial decimal stepper positioner.
// Instantiates sdsp_front, sdsp_queue and sdsp_back; uses sdsp_pkg.
//
// Each item (a received byte or a time tick) yields exactly one result item.
// The block sustains one item per clock: the execution unit applies one
// command per cycle behind a two-entry queue, so items are accepted back to
// back while results are taken; when a result is held at the output, the
// input stalls once both queue entries are full. An accepted item is written
// into the queue, and its result is registered at the output when the
// execution unit pops it from the head of the queue.
// Up to MaxDigits digits are collected; a carriage return loads the
// target, saturated at 999, and motion proceeds one phase per phase_ticks
// ticks.
module serial_decimal_stepper_positioner_unit #(
  parameter int unsigned MaxDigits = sdsp_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdsp_pkg::out_item_t out_item_o
);

  sdsp_pkg::cmd_t    front_cmd;
  sdsp_pkg::cmd_t    head_cmd;
  sdsp_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  assign in_stall_o = q_stat.full;
  assign push       = in_valid_i && !q_stat.full;

  sdsp_front u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  sdsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  sdsp_back #(
    .MaxDigits (MaxDigits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_stat.not_empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> q_stat.not_empty)
    else $error("queue full while empty");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.position <= sdsp_pkg::POS_MAX)
    else $error("position beyond range");

  a_idle_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.moving) |-> out_item_o.coil_drive == sdsp_pkg::COIL_PHASE0)
    else $error("coils not at phase zero while idle");

  a_echo_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.echo_valid) |->
      (!out_item_o.line_done && out_item_o.echo_byte >= sdsp_pkg::CHAR_ZERO &&
       out_item_o.echo_byte <= sdsp_pkg::CHAR_NINE))
    else $error("echo of a non-digit");

endmodule

/* tb/sv/positioner_shadow_pkg.sv */
// Scoreboard for the serial decimal stepper positioner: tracks digits, target,
// position, coil phase and hold count, and checks each result item in order.
// Depends on sdsp_pkg for the item structs and character constants.
`timescale 1ns / 1ps

package positioner_shadow_pkg;
  import sdsp_pkg::*;

  class positioner_shadow;
    logic [15:0] hold_limit;
    logic [3:0]  digits [MAX_DIGITS_DEF];
    int unsigned n_digits;
    logic [9:0]  target;
    logic [9:0]  cur_pos;
    logic [1:0]  phase;
    logic [15:0] held;
    logic [3:0]  coil_pattern [4];
    out_item_t   expected_status [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned lines_seen;
    int unsigned echoes_seen;
    int unsigned steps_seen;

    function new();
      hold_limit   = PHASE_RESET;
      n_digits     = 0;
      target       = '0;
      cur_pos      = '0;
      phase        = '0;
      held         = '0;
      coil_pattern = '{4'h5, 4'h6, 4'hA, 4'h9};
      foreach (digits[i]) digits[i] = '0;
      mismatches   = 0;
      results_seen = 0;
      lines_seen   = 0;
      echoes_seen  = 0;
      steps_seen   = 0;
    endfunction

    function void set_hold_limit(input logic [15:0] v);
      hold_limit = v;
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    function bit in_motion();
      return (cur_pos != target) || (phase != 2'd0);
    endfunction

    function void step_phase();
      int unsigned here;
      int unsigned goal;
      here = cur_pos * 4 + phase;
      goal = target * 4;
      if (here < goal) here++;
      else if (here > goal) here--;
      cur_pos = here[11:2];
      phase   = here[1:0];
      steps_seen++;
    endfunction

    function void apply_tick();
      if (!in_motion()) begin
        held = '0;
        return;
      end
      held = held + 16'd1;
      if (held >= hold_limit) begin
        held = '0;
        step_phase();
      end
    endfunction

    function void end_line();
      int unsigned value;
      value = 0;
      if (n_digits == 0) return;
      for (int unsigned i = 0; i < n_digits; i++) value = value * 10 + digits[i];
      if (value > POS_MAX) value = POS_MAX;
      target   = value[9:0];
      n_digits = 0;
    endfunction

    function void note_item(input in_item_t it);
      out_item_t r;
      r = '0;
      if (it.op) begin
        apply_tick();
      end else if (it.rx_byte == CHAR_CR) begin
        end_line();
        r.line_done = 1'b1;
        lines_seen++;
      end else if (it.rx_byte >= CHAR_ZERO && it.rx_byte <= CHAR_NINE) begin
        if (n_digits < MAX_DIGITS_DEF) begin
          digits[n_digits] = 4'(it.rx_byte - CHAR_ZERO);
          n_digits++;
          r.echo_valid = 1'b1;
          r.echo_byte  = it.rx_byte;
          echoes_seen++;
        end
      end
      r.coil_drive = coil_pattern[phase];
      r.position   = cur_pos;
      r.moving     = in_motion();
      expected_status.push_back(r);
    endfunction

    task flag_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch: %s on result %0d, got %0h, expected %0h",
               what, results_seen, got, want);
      mismatches++;
    endtask

    task check_status(input out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_status.size() == 0) begin
        flag_mismatch("result with nothing pending", 16'(got.position), '0);
        return;
      end
      want = expected_status.pop_front();
      if (got.echo_valid !== want.echo_valid)
        flag_mismatch("echo_valid", 16'(got.echo_valid), 16'(want.echo_valid));
      if (got.echo_byte !== want.echo_byte)
        flag_mismatch("echo_byte", 16'(got.echo_byte), 16'(want.echo_byte));
      if (got.line_done !== want.line_done)
        flag_mismatch("line_done", 16'(got.line_done), 16'(want.line_done));
      if (got.coil_drive !== want.coil_drive)
        flag_mismatch("coil_drive", 16'(got.coil_drive), 16'(want.coil_drive));
      if (got.position !== want.position)
        flag_mismatch("position", 16'(got.position), 16'(want.position));
      if (got.moving !== want.moving)
        flag_mismatch("moving", 16'(got.moving), 16'(want.moving));
    endtask
  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top of the positioner testbench: clock, reset, item driver, result sink
// and the phase_ticks schedule. Uses sdsp_pkg and positioner_shadow_pkg.
`timescale 1ns / 1ps

module tb_top;
  import sdsp_pkg::*;
  import positioner_shadow_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_OFF    = 80;
  localparam int unsigned N_SEGS      = 6;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  positioner_shadow shadow;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned live_items = 0;
  int unsigned hold_settings = 0;

  logic [15:0] seg_limit [N_SEGS] = '{16'd1, 16'd2, 16'd0, 16'd65535, 16'd3, 16'd1};
  int unsigned seg_items [N_SEGS] = '{230, 230, 200, 80, 200, 160};

  serial_decimal_stepper_positioner_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[serial_decimal_stepper_positioner_unit] ERROR");
      $finish;
    end
  end

  // result sink; a requested hold-off keeps the output stalled while hold_left runs down
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) shadow.check_status(out_item_o);
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_OFF - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= rst_ni && ($urandom_range(0, 99) < rcv_idle);
    end
  end

  task automatic offer_item(input in_item_t it);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.note_item(it);
    if (it.op || it.rx_byte == CHAR_CR || (it.rx_byte >= CHAR_ZERO && it.rx_byte <= CHAR_NINE))
      live_items++;
  endtask

  task automatic offer_byte(input logic [7:0] b);
    in_item_t it;
    it.op      = 1'b0;
    it.rx_byte = b;
    offer_item(it);
  endtask

  task automatic offer_ticks(input int unsigned n);
    in_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.op      = 1'b1;
      it.rx_byte = 8'($urandom_range(0, 255));
      offer_item(it);
    end
  endtask

  task automatic offer_line(input int unsigned n_dig, input bit with_cr);
    for (int unsigned i = 0; i < n_dig; i++) begin
      if ($urandom_range(0, 99) < 4) offer_byte(8'($urandom_range(0, 255)));
      offer_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    if (with_cr) offer_byte(CHAR_CR);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0 || hold_left != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_hold_limit(input logic [15:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.set_hold_limit(v);
    hold_settings++;
  endtask

  function automatic int unsigned pick_digit_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 45) return 1;
    if (r < 80) return 2;
    if (r < 92) return 3;
    return $urandom_range(4, 6);
  endfunction

  task automatic offer_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) offer_ticks($urandom_range(1, 12));
    else if (r < 78) offer_line(pick_digit_count(), 1'b1);
    else if (r < 88) offer_byte(8'($urandom_range(0, 255)));
    else if (r < 94) offer_line($urandom_range(1, 4), 1'b0);
    else offer_ticks($urandom_range(20, 60));
  endtask

  initial begin
    int unsigned goal;
    shadow = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset hold value: ticks count up without a step
    offer_line(1, 1'b1);
    offer_ticks(2);

    write_hold_limit(16'd0);
    hold_settings = 1;
    offer_ticks(1);
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(CHAR_ZERO - 8'd1);
    offer_byte(CHAR_NINE + 8'd1);
    offer_byte(CHAR_CR);
    offer_byte(CHAR_NINE);
    offer_byte(CHAR_NINE);
    offer_byte(CHAR_NINE);
    offer_byte(CHAR_ZERO + 8'd7);
    offer_byte(CHAR_CR);
    offer_ticks(3);
    offer_byte(CHAR_ZERO);
    offer_byte(CHAR_CR);
    offer_ticks(5);

    for (int unsigned s = 0; s < N_SEGS; s++) begin
      write_hold_limit(seg_limit[s]);
      case (s % 3)
        0: begin
          snd_idle = 16;
          rcv_idle = 63;
        end
        1: begin
          snd_idle = 63;
          rcv_idle = 16;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          holds_asked = holds_asked + 1;
        end
      endcase
      goal = live_items + seg_items[s];
      while (live_items < goal) offer_random();
    end

    drain();
    $display("covered %0d items over %0d phase_ticks settings: %0d lines, %0d echoes, %0d steps",
             live_items, hold_settings, shadow.lines_seen, shadow.echoes_seen,
             shadow.steps_seen);
    $display("%0d results checked, %0d mismatches", shadow.results_seen, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("[serial_decimal_stepper_positioner_unit] OK");
    end else begin
      $display("[serial_decimal_stepper_positioner_unit] ERROR");
    end
    $finish;
  end

endmodule
